>>> rtl/rtt_tsc_pkg.sv
package rtt_tsc_pkg;

  // Round condition codes, as carried on the result stream
  typedef enum logic [1:0] {
    COND_ABOVE = 2'd0,
    COND_NEAR  = 2'd1,
    COND_BELOW = 2'd2
  } cond_e;

  // Item kind on the input stream
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_INIT   = 1'b1
  } op_e;

  // Outcome of comparing one flow's observed delay against its target
  typedef struct packed {
    logic above;
    logic near;
  } delay_cmp_t;

endpackage

>>> rtl/rtt_tsc_delay_cmp.sv
module rtt_tsc_delay_cmp #(
  parameter int unsigned DELAY_BITS = 32
) (
  input  logic [DELAY_BITS-1:0]   observed_i,
  input  logic [DELAY_BITS-1:0]   target_i,
  output rtt_tsc_pkg::delay_cmp_t cmp_o
);

  localparam int unsigned WIDE_BITS = DELAY_BITS + 4;

  logic [WIDE_BITS-1:0] obs_x10;
  logic [WIDE_BITS-1:0] tgt_x9;

  // 10*obs = 8*obs + 2*obs, 9*tgt = 8*tgt + tgt
  assign obs_x10 = {1'b0, observed_i, 3'b000} + {3'b000, observed_i, 1'b0};
  assign tgt_x9  = {1'b0, target_i, 3'b000} + {4'b0000, target_i};

  assign cmp_o.above = observed_i > target_i;
  assign cmp_o.near  = obs_x10 >= tgt_x9;

endmodule

>>> rtl/rtt_throttle_step_controller_unit.sv
// Path of a result: the round's last sample goes through the delay compare into the input register,
// then the update goes into the result register, from which it leaves on the master side.
// Throughput: one item per cycle, unless a round-closing sample waits on a stalled result.
// Non-final samples and init items produce no result and drain even while a result is stalled.
// Reset: fraction and step clear to zero, the condition window fills with near-target codes,
// round flags and the window pointer clear, both pipeline valid bits drop.
module rtt_throttle_step_controller_unit #(
  parameter int unsigned WINDOW_LENGTH = 3,
  parameter int unsigned DELAY_BITS    = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // observed_delay, target_delay, start_fraction (from bit 0 up), zero padded
  input  logic [((2*DELAY_BITS+FRACTION_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic s_axis_tlast,
  // op
  input  logic s_axis_tuser,

  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // fraction, step, condition (from bit 0 up), zero padded
  output logic [((2*FRACTION_BITS+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned STEP_BITS  = FRACTION_BITS - 2;
  localparam int unsigned FRAC_W     = FRACTION_BITS + 1;
  localparam int unsigned SUM_BITS   = FRACTION_BITS + 2;
  localparam int unsigned PTR_W      = $clog2(WINDOW_LENGTH);
  localparam int unsigned OUT_W      = ((2*FRACTION_BITS+7)/8)*8;
  localparam int unsigned FRAC_ONE   = 1 << FRACTION_BITS;
  localparam int unsigned INIT_INT   = (FRAC_ONE + 5) / 10;
  localparam int unsigned MIN_INT    = (FRAC_ONE + 5000) / 10000;
  localparam logic signed [STEP_BITS-1:0] INIT_STEP = STEP_BITS'(INIT_INT);
  localparam logic [FRAC_W-1:0] FLOOR_FRAC = FRAC_W'(MIN_INT);
  localparam logic [FRAC_W-1:0] MAX_FRAC = FRAC_W'(FRAC_ONE - MIN_INT);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(WINDOW_LENGTH - 1);

  // Input stage
  rtt_tsc_pkg::delay_cmp_t cmp_in;
  logic                    s1_valid_q;
  rtt_tsc_pkg::op_e        s1_op_q;
  logic                    s1_last_q;
  rtt_tsc_pkg::delay_cmp_t s1_cmp_q;
  logic [FRACTION_BITS-1:0] s1_start_q;

  // Controller state
  logic [FRAC_W-1:0]            frac_q, frac_d;
  logic signed [STEP_BITS-1:0]  step_q, step_d;
  rtt_tsc_pkg::cond_e           win_q [WINDOW_LENGTH];
  rtt_tsc_pkg::cond_e           win_d [WINDOW_LENGTH];
  logic [PTR_W-1:0]             ptr_q, ptr_d;
  logic                         above_q, near_q;

  // Result stage
  logic             m_valid_q;
  logic [OUT_W-1:0] m_data_q, m_data_d;

  logic               s_xfer;
  logic               makes_result;
  logic               out_free;
  logic               fire;
  logic               any_above, any_near;
  rtt_tsc_pkg::cond_e cond;
  logic               all_above, all_below;
  logic [STEP_BITS-1:0]         mag;
  logic [STEP_BITS:0]           half_ext;
  logic signed [STEP_BITS-1:0]  half, flipped;
  logic signed [SUM_BITS-1:0]   sum;

  rtt_tsc_delay_cmp #(
    .DELAY_BITS(DELAY_BITS)
  ) u_delay_cmp (
    .observed_i(s_axis_tdata[DELAY_BITS-1:0]),
    .target_i  (s_axis_tdata[2*DELAY_BITS-1:DELAY_BITS]),
    .cmp_o     (cmp_in)
  );

  assign makes_result  = s1_valid_q && (s1_op_q == rtt_tsc_pkg::OP_SAMPLE) && s1_last_q;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign fire          = s1_valid_q && (!makes_result || out_free);
  assign s_axis_tready = !s1_valid_q || fire;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_comb begin
    any_above = above_q | s1_cmp_q.above;
    any_near  = near_q | s1_cmp_q.near;
    if (any_above) begin
      cond = rtt_tsc_pkg::COND_ABOVE;
    end else if (any_near) begin
      cond = rtt_tsc_pkg::COND_NEAR;
    end else begin
      cond = rtt_tsc_pkg::COND_BELOW;
    end

    win_d = win_q;
    win_d[ptr_q] = cond;
    ptr_d = (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_W'(1);

    all_above = 1'b1;
    all_below = 1'b1;
    for (int i = 0; i < WINDOW_LENGTH; i++) begin
      if (win_d[i] != rtt_tsc_pkg::COND_ABOVE) all_above = 1'b0;
      if (win_d[i] != rtt_tsc_pkg::COND_BELOW) all_below = 1'b0;
    end

    // Halve magnitude rounding away from zero, then negate
    mag      = step_q[STEP_BITS-1] ? -step_q : step_q;
    half_ext = {1'b0, mag} + (STEP_BITS+1)'(1);
    half     = half_ext[STEP_BITS:1];
    flipped  = step_q[STEP_BITS-1] ? half : -half;

    priority if (all_above) begin
      step_d = -INIT_STEP;
    end else if (all_below) begin
      step_d = INIT_STEP;
    end else if (cond == rtt_tsc_pkg::COND_ABOVE) begin
      step_d = (!step_q[STEP_BITS-1] && (step_q != '0)) ? flipped : step_q;
    end else begin
      step_d = step_q[STEP_BITS-1] ? flipped : step_q;
    end

    sum = $signed({1'b0, frac_q}) + $signed({{4{step_d[STEP_BITS-1]}}, step_d});
    priority if (sum[SUM_BITS-1] || (sum == '0)) begin
      frac_d = FLOOR_FRAC;
    end else if (sum[FRAC_W-1:0] >= MAX_FRAC) begin
      frac_d = MAX_FRAC;
    end else begin
      frac_d = sum[FRAC_W-1:0];
    end

    m_data_d = OUT_W'({cond, step_d, frac_d[FRACTION_BITS-1:0]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
      frac_q     <= '0;
      step_q     <= '0;
      ptr_q      <= '0;
      above_q    <= 1'b0;
      near_q     <= 1'b0;
      for (int i = 0; i < WINDOW_LENGTH; i++) begin
        win_q[i] <= rtt_tsc_pkg::COND_NEAR;
      end
    end else begin
      if (s_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end

      if (fire && makes_result) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      if (fire) begin
        if (s1_op_q == rtt_tsc_pkg::OP_INIT) begin
          frac_q <= {1'b0, s1_start_q};
          step_q <= INIT_STEP;
        end else if (s1_last_q) begin
          // Close the round: clear flags, log condition, adapt step and fraction
          above_q <= 1'b0;
          near_q  <= 1'b0;
          win_q   <= win_d;
          ptr_q   <= ptr_d;
          step_q  <= step_d;
          frac_q  <= frac_d;
        end else begin
          above_q <= any_above;
          near_q  <= any_near;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      s1_op_q    <= rtt_tsc_pkg::op_e'(s_axis_tuser);
      s1_last_q  <= s_axis_tlast;
      s1_cmp_q   <= cmp_in;
      s1_start_q <= s_axis_tdata[2*DELAY_BITS+FRACTION_BITS-1:2*DELAY_BITS];
    end
    if (fire && makes_result) begin
      m_data_q <= m_data_d;
    end
  end

endmodule

>>> dv/rtt_throttle_step_controller_unit_tb.sv
`timescale 1ns / 100ps

module rtt_throttle_step_controller_unit_tb;

  localparam int FRAC_ONE  = 1 << 16;
  localparam int INIT_STEP = (FRAC_ONE + 5) / 10;
  localparam int FLOOR_FRAC = (FRAC_ONE + 5000) / 10000;
  localparam int MAX_FRAC  = FRAC_ONE - FLOOR_FRAC;
  localparam int WIN_LEN   = 3;
  localparam int PHASE_ITEMS = 325;

  typedef struct {
    rtt_tsc_pkg::op_e op;
    logic [31:0]      observed;
    logic [31:0]      target;
    logic             last;
    logic [15:0]      start;
  } flow_item_t;

  typedef struct {
    logic [15:0]        fraction;
    logic [13:0]        step;
    rtt_tsc_pkg::cond_e cond;
  } throttle_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // observed_delay, target_delay, start_fraction (from bit 0 up)
  logic [79:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  // op
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // fraction, step, condition (from bit 0 up)
  logic [31:0] m_axis_tdata;

  flow_item_t       pending_items[$];
  throttle_result_t expected_results[$];
  flow_item_t       drive_item;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int error_count = 0;
  int results_checked = 0;
  int samples_sent = 0;
  int inits_sent = 0;
  int cond_seen[3] = '{0, 0, 0};

  // predicted block state
  int                 model_fraction = 0;
  int                 model_step = 0;
  rtt_tsc_pkg::cond_e model_window[WIN_LEN];
  int                 model_ptr = 0;
  bit                 model_any_above = 0;
  bit                 model_any_near = 0;

  rtt_throttle_step_controller_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  task automatic update_throttle(input logic op, input logic [31:0] obs, input logic [31:0] tgt,
                                 input logic last, input logic [15:0] start);
    longint unsigned    o, t;
    rtt_tsc_pkg::cond_e cond;
    bit                 all_above, all_below;
    int                 mag, sum;
    throttle_result_t   res;
    o = obs;
    t = tgt;
    if (op == rtt_tsc_pkg::OP_INIT) begin
      model_fraction = start;
      model_step = INIT_STEP;
      return;
    end
    if (o > t) model_any_above = 1;
    if (o * 10 >= t * 9) model_any_near = 1;
    if (!last) return;
    cond = model_any_above ? rtt_tsc_pkg::COND_ABOVE :
           (model_any_near ? rtt_tsc_pkg::COND_NEAR : rtt_tsc_pkg::COND_BELOW);
    model_any_above = 0;
    model_any_near = 0;
    model_window[model_ptr] = cond;
    model_ptr = (model_ptr + 1) % WIN_LEN;
    all_above = 1;
    all_below = 1;
    foreach (model_window[i]) begin
      if (model_window[i] != rtt_tsc_pkg::COND_ABOVE) all_above = 0;
      if (model_window[i] != rtt_tsc_pkg::COND_BELOW) all_below = 0;
    end
    if (all_above) begin
      model_step = -INIT_STEP;
    end else if (all_below) begin
      model_step = INIT_STEP;
    end else if ((cond == rtt_tsc_pkg::COND_ABOVE && model_step > 0) ||
                 (cond != rtt_tsc_pkg::COND_ABOVE && model_step < 0)) begin
      // halve with rounding away from zero, then flip the sign
      mag = (model_step < 0) ? -model_step : model_step;
      mag = (mag + 1) >>> 1;
      model_step = (model_step < 0) ? mag : -mag;
    end
    sum = model_fraction + model_step;
    if (sum <= 0) model_fraction = FLOOR_FRAC;
    else model_fraction = (sum < MAX_FRAC) ? sum : MAX_FRAC;
    res.fraction = model_fraction[15:0];
    res.step = model_step[13:0];
    res.cond = cond;
    expected_results.push_back(res);
  endtask

  task automatic push_item(input rtt_tsc_pkg::op_e op, input logic [31:0] obs,
                           input logic [31:0] tgt, input logic last, input logic [15:0] start);
    flow_item_t it;
    it.op = op;
    it.observed = obs;
    it.target = tgt;
    it.last = last;
    it.start = start;
    pending_items.push_back(it);
  endtask

  task automatic push_sample(input logic [31:0] obs, input logic [31:0] tgt, input logic last);
    push_item(rtt_tsc_pkg::OP_SAMPLE, obs, tgt, last, 16'($urandom));
  endtask

  task automatic push_init(input logic [15:0] start);
    push_item(rtt_tsc_pkg::OP_INIT, $urandom, $urandom, 1'($urandom), start);
  endtask

  // pick an observed/target pair whose comparison lands in the given class
  task automatic make_delays(input rtt_tsc_pkg::cond_e kind, output logic [31:0] obs,
                             output logic [31:0] tgt);
    longint unsigned t, lo, hi, r;
    r = {$urandom, $urandom};
    case ($urandom_range(3))
      0: t = $urandom_range(100);
      1: t = $urandom_range(20000);
      default: t = $urandom;
    endcase
    case (kind)
      rtt_tsc_pkg::COND_ABOVE: begin
        if (t == 64'hFFFF_FFFF) t = t - 1;
        lo = t + 1;
        hi = $urandom_range(1) ? 64'hFFFF_FFFF : lo + $urandom_range(50);
        if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
      end
      rtt_tsc_pkg::COND_NEAR: begin
        lo = (9 * t + 9) / 10;
        hi = t;
      end
      default: begin
        if (t == 0) t = 1;
        hi = (9 * t - 1) / 10;
        lo = $urandom_range(1) ? 0 : ((hi > 50) ? hi - 50 : 0);
      end
    endcase
    r = lo + r % (hi - lo + 1);
    obs = r[31:0];
    tgt = t[31:0];
  endtask

  task automatic push_round(input rtt_tsc_pkg::cond_e kind, input bit noisy);
    int                 len, forced;
    logic [31:0]        obs, tgt;
    rtt_tsc_pkg::cond_e k;
    len = ($urandom_range(9) == 0) ? $urandom_range(8, 5) : $urandom_range(4, 1);
    forced = $urandom_range(len - 1);
    for (int i = 0; i < len; i++) begin
      if (noisy) begin
        obs = $urandom;
        tgt = $urandom;
      end else begin
        k = (i == forced) ? kind : rtt_tsc_pkg::cond_e'($urandom_range(2, kind));
        make_delays(k, obs, tgt);
      end
      // drop an init into the middle of a round now and then
      if (i != 0 && $urandom_range(29) == 0) push_init(16'($urandom));
      push_sample(obs, tgt, i == len - 1);
    end
  endtask

  task automatic fill_random_phase();
    int                 target_size;
    rtt_tsc_pkg::cond_e kind;
    kind = rtt_tsc_pkg::COND_NEAR;
    target_size = pending_items.size() + PHASE_ITEMS;
    while (pending_items.size() < target_size) begin
      if ($urandom_range(24) == 0) push_init(16'($urandom));
      if ($urandom_range(99) >= 55) kind = rtt_tsc_pkg::cond_e'($urandom_range(2));
      push_round(kind, $urandom_range(9) == 0);
    end
  endtask

  task automatic fill_directed();
    push_sample(32'd0, 32'd0, 1'b1);                  // near with zero step: step holds
    push_sample(32'd8, 32'd9, 1'b0);                  // just below the near bound
    push_sample(32'd0, 32'hFFFF_FFFF, 1'b1);
    push_sample(32'd0, 32'd1, 1'b1);
    push_sample(32'd3, 32'd100, 1'b1);                // window full of below
    push_item(rtt_tsc_pkg::OP_INIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
    push_sample(32'd0, 32'd5, 1'b1);                  // saturate at max
    push_sample(32'hFFFF_FFFF, 32'd0, 1'b1);
    push_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    push_sample(32'd9, 32'd10, 1'b1);                 // exactly on the near bound
    push_item(rtt_tsc_pkg::OP_INIT, 32'd0, 32'd0, 1'b0, 16'h0000);
    push_sample(32'd5, 32'd4, 1'b1);                  // negative sum clamps to min
    push_sample(32'd5, 32'd4, 1'b1);
    push_sample(32'd5, 32'd4, 1'b1);
    push_sample(32'd5, 32'd4, 1'b0);
    // init mid-round keeps flags
    push_item(rtt_tsc_pkg::OP_INIT, 32'd7, 32'd7, 1'b1, 16'h8000);
    push_sample(32'd0, 32'd9, 1'b1);
    push_item(rtt_tsc_pkg::OP_SAMPLE, 32'd1, 32'd2, 1'b1, 16'hA5A5);
    push_item(rtt_tsc_pkg::OP_SAMPLE, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 16'h5A5A);
    push_item(rtt_tsc_pkg::OP_SAMPLE, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 16'hFFFF);
  endtask

  // driver: hold the transfer until accepted, otherwise advance or idle
  always @(posedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        drive_item = pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {drive_item.start, drive_item.target, drive_item.observed};
        s_axis_tlast  <= drive_item.last;
        s_axis_tuser  <= drive_item.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // monitor: predict on each input transfer, check each output transfer
  always @(posedge clk_i) begin
    throttle_result_t exp_res;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == rtt_tsc_pkg::OP_INIT) inits_sent++;
        else samples_sent++;
        update_throttle(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
                        s_axis_tlast, s_axis_tdata[79:64]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result tdata=%h", $time, m_axis_tdata);
          error_count++;
        end else begin
          exp_res = expected_results.pop_front();
          results_checked++;
          if (m_axis_tdata[31:30] <= 2) cond_seen[m_axis_tdata[31:30]]++;
          if (m_axis_tdata[15:0] !== exp_res.fraction) begin
            $display("%0t: fraction mismatch expected %0d actual %0d", $time,
                     exp_res.fraction, m_axis_tdata[15:0]);
            error_count++;
          end
          if (m_axis_tdata[29:16] !== exp_res.step) begin
            $display("%0t: step mismatch expected %0d actual %0d", $time,
                     $signed(exp_res.step), $signed(m_axis_tdata[29:16]));
            error_count++;
          end
          if (m_axis_tdata[31:30] !== exp_res.cond) begin
            $display("%0t: condition mismatch expected %0d actual %0d", $time,
                     exp_res.cond, m_axis_tdata[31:30]);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    int idle_cfg[4][2];
    idle_cfg = '{'{0, 0}, '{78, 0}, '{0, 78}, '{14, 14}};
    foreach (model_window[i]) model_window[i] = rtt_tsc_pkg::COND_NEAR;
    fill_directed();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < 4; p++) begin
      @(negedge clk_i);
      sender_idle_pct = idle_cfg[p][0];
      receiver_stall_pct = idle_cfg[p][1];
      fill_random_phase();
      while (pending_items.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    end
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    $display("covered %0d samples and %0d inits over four idling phases", samples_sent,
             inits_sent);
    $display("checked %0d round results: %0d above, %0d near, %0d below", results_checked,
             cond_seen[0], cond_seen[1], cond_seen[2]);
    if (error_count == 0) begin
      $display("rtt_throttle_step_controller_unit_tb: PASS");
    end else begin
      $display("rtt_throttle_step_controller_unit_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("rtt_throttle_step_controller_unit_tb: FAIL");
    $finish;
  end

endmodule

>>> rtt_throttle_step_controller_unit.f
rtl/rtt_tsc_pkg.sv
rtl/rtt_tsc_delay_cmp.sv
rtl/rtt_throttle_step_controller_unit.sv
dv/rtt_throttle_step_controller_unit_tb.sv
